// ===== hdl/spt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;

    localparam int TEX_WIDTH   = 64;
    localparam int TEX_HEIGHT  = 64;
    localparam int TEXEL_SCALE = 256;
    localparam int HALF_SCALE  = 128;
    localparam int TEXX_GAIN   = TEXEL_SCALE * TEX_WIDTH;

    localparam int DIV_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_POS_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAYER_POS_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd7;

    typedef struct packed {
        logic signed [31:0] player_pos_x;
        logic signed [31:0] player_pos_y;
        logic signed [17:0] view_dir_x;
        logic signed [17:0] view_dir_y;
        logic signed [17:0] camera_plane_x;
        logic signed [17:0] camera_plane_y;
        logic [12:0]        screen_width;
        logic [12:0]        screen_height;
    } cfg_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] sprite_pos_x;
        logic signed [31:0] sprite_pos_y;
        logic [11:0]        column;
        logic [11:0]        row;
        logic [30:0]        column_depth;
    } item_t;

    typedef struct packed {
        logic        visible;
        logic [11:0] box_left;
        logic [11:0] box_right;
        logic [11:0] box_top;
        logic [11:0] box_bottom;
        logic        draw_pixel;
        logic [7:0]  texel_x;
        logic [7:0]  texel_y;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [12:0] eff_dim(input logic [12:0] v);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > 13'd4096) begin
            r = 13'd4096;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DIV_W-1:0] mag64(input logic signed [DIV_W-1:0] v);
        logic [DIV_W-1:0] r;
        r = v[DIV_W-1] ? DIV_W'(-v) : DIV_W'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/spt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spt_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  spt_pkg::item_t     in_item,
    output logic               q_valid,
    output spt_pkg::item_t     q_item,
    input  wire logic          q_pop
);
    import spt_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/spt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spt_div (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  spt_pkg::div_req_t req,
    output spt_pkg::div_rsp_t rsp
);
    import spt_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   shifted;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            if (!trial[DIV_W]) begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/spt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spt_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  spt_pkg::cfg_t      cfg,
    input  wire logic          q_valid,
    input  spt_pkg::item_t     q_item,
    output logic               q_pop,
    output spt_pkg::div_req_t  div_req,
    input  spt_pkg::div_rsp_t  div_rsp,
    output logic               m_valid,
    input  wire logic          m_ready,
    output spt_pkg::result_t   m_res
);
    import spt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
        ST_DQ, ST_MC0, ST_MC1, ST_DC, ST_DH, ST_DW, ST_BOX,
        ST_QX, ST_DX, ST_DY, ST_DONE
    } state_t;

    state_t             state_reg;
    item_t              item_reg;
    logic signed [32:0] sx_reg;
    logic signed [32:0] sy_reg;
    logic signed [51:0] acc_reg;
    logic signed [20:0] det_reg;
    logic signed [51:0] tnx_reg;
    logic signed [51:0] tny_reg;
    logic signed [70:0] prod_reg;
    logic               neg_reg;
    logic [30:0]        cam_reg;
    logic signed [15:0] centre_reg;
    logic [15:0]        hh_reg;
    logic [15:0]        ww_reg;
    logic [11:0]        left_reg;
    logic [11:0]        right_reg;
    logic [11:0]        top_reg;
    logic [11:0]        bottom_reg;
    logic               draw_reg;
    logic [7:0]         texx_reg;
    logic [7:0]         texy_reg;
    div_req_t           div_req_reg;
    logic               m_valid_reg;
    result_t            m_res_reg;

    logic signed [17:0] mul_a;
    logic signed [52:0] mul_b;
    logic signed [70:0] mul_p;
    logic [12:0]        ws;
    logic [12:0]        hs;
    logic signed [51:0] tn_diff;
    logic signed [36:0] det_diff;
    logic [DIV_W-1:0]   qm;
    logic [30:0]        cam_sat;
    logic signed [15:0] centre_sat;
    logic [15:0]        size_sat;
    logic [7:0]         tex_sat;
    logic [15:0]        row_end_raw;
    logic [11:0]        row_end;
    logic signed [16:0] row_start_raw;
    logic [11:0]        row_start;
    logic signed [17:0] col_end_raw;
    logic [11:0]        col_end;
    logic signed [17:0] col_start_raw;
    logic [11:0]        col_start;
    logic               pix_go;
    logic               div_go;
    logic signed [18:0] col_off;
    logic signed [63:0] nx;
    logic signed [63:0] ny;

    assign ws       = eff_dim(cfg.screen_width);
    assign hs       = eff_dim(cfg.screen_height);
    assign mul_p    = mul_a * mul_b;
    assign tn_diff  = acc_reg - prod_reg[51:0];
    assign det_diff = $signed(acc_reg[36:0]) - $signed(prod_reg[36:0]);
    assign qm       = div_rsp.quotient;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_M0: begin
                mul_a = cfg.camera_plane_x;
                mul_b = 53'(cfg.view_dir_y);
            end
            ST_M1: begin
                mul_a = cfg.view_dir_x;
                mul_b = 53'(cfg.camera_plane_y);
            end
            ST_M2: begin
                mul_a = cfg.view_dir_y;
                mul_b = 53'(sx_reg);
            end
            ST_M3: begin
                mul_a = cfg.view_dir_x;
                mul_b = 53'(sy_reg);
            end
            ST_M4: begin
                mul_a = cfg.camera_plane_x;
                mul_b = 53'(sy_reg);
            end
            ST_M5: begin
                mul_a = cfg.camera_plane_y;
                mul_b = 53'(sx_reg);
            end
            ST_MC0: begin
                mul_a = $signed({6'd0, ws[12:1]});
                mul_b = 53'(tnx_reg) + 53'(tny_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        cam_sat = (|qm[DIV_W-1:31]) ? 31'h7FFF_FFFF : qm[30:0];
        if (neg_reg) begin
            centre_sat = (|qm[DIV_W-1:16] || qm[15:0] > 16'h8000) ?
                         16'sh8000 : $signed(16'(-qm[15:0]));
        end else begin
            centre_sat = (|qm[DIV_W-1:15]) ? 16'sh7FFF : $signed(qm[15:0]);
        end
        size_sat = (|qm[DIV_W-1:16]) ? 16'hFFFF : qm[15:0];
        tex_sat  = neg_reg ? 8'd0 : ((|qm[DIV_W-1:16]) ? 8'hFF : qm[15:8]);
    end

    always_comb begin
        row_end_raw   = 16'(hh_reg[15:1]) + 16'(hs[12:1]);
        row_end       = (row_end_raw > 16'(hs - 13'd1)) ? 12'(hs - 13'd1) :
                        row_end_raw[11:0];
        row_start_raw = $signed({5'd0, hs[12:1]}) - $signed({2'd0, hh_reg[15:1]});
        if (row_start_raw < 0) begin
            row_start = 12'd0;
        end else if (row_start_raw > $signed({5'd0, row_end})) begin
            row_start = row_end;
        end else begin
            row_start = row_start_raw[11:0];
        end
        col_end_raw = 18'(centre_reg) + $signed({3'd0, ww_reg[15:1]});
        if (col_end_raw < 0) begin
            col_end = 12'd0;
        end else if (col_end_raw > $signed({5'd0, ws - 13'd1})) begin
            col_end = 12'(ws - 13'd1);
        end else begin
            col_end = col_end_raw[11:0];
        end
        col_start_raw = 18'(centre_reg) - $signed({3'd0, ww_reg[15:1]});
        if (col_start_raw < 0) begin
            col_start = 12'd0;
        end else if (col_start_raw > $signed({6'd0, col_end})) begin
            col_start = col_end;
        end else begin
            col_start = col_start_raw[11:0];
        end
    end

    always_comb begin
        pix_go = (item_reg.column >= left_reg) && (item_reg.column < right_reg) &&
                 (item_reg.row >= top_reg) && (item_reg.row < bottom_reg) &&
                 (cam_reg != 31'd0) && (item_reg.column != 12'd0) &&
                 ({1'b0, item_reg.column} < ws) &&
                 (cam_reg < item_reg.column_depth) &&
                 (ww_reg != 16'd0) && (hh_reg != 16'd0);
        col_off = $signed({7'd0, item_reg.column}) - 19'(col_start_raw);
        nx = 64'(col_off) * 64'(TEXX_GAIN);
        ny = (64'($signed({1'b0, item_reg.row})) * 64'(TEXEL_SCALE)
              - 64'($signed({1'b0, hs})) * 64'(HALF_SCALE)
              + 64'($signed({1'b0, hh_reg})) * 64'(HALF_SCALE)) * 64'(TEX_HEIGHT);
    end

    always_comb begin
        case (state_reg) inside
            ST_M7:               div_go = (det_reg != 21'sd0);
            ST_MC1:              div_go = 1'b1;
            ST_DC, ST_DH, ST_DX: div_go = div_rsp.done;
            ST_QX:               div_go = pix_go;
            default:             div_go = 1'b0;
        endcase
    end

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign div_req = div_req_reg;
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            div_req_reg.start <= 1'b0;
            m_valid_reg       <= 1'b0;
            cam_reg           <= '0;
            centre_reg        <= '0;
            hh_reg            <= '0;
            ww_reg            <= '0;
            left_reg          <= '0;
            right_reg         <= '0;
            top_reg           <= '0;
            bottom_reg        <= '0;
        end else begin
            div_req_reg.start <= div_go;
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg <= q_item;
                        sx_reg   <= 33'(q_item.sprite_pos_x) - 33'(cfg.player_pos_x);
                        sy_reg   <= 33'(q_item.sprite_pos_y) - 33'(cfg.player_pos_y);
                        draw_reg <= 1'b0;
                        texx_reg <= 8'd0;
                        texy_reg <= 8'd0;
                        state_reg <= (q_item.opcode == OP_LOAD) ? ST_M0 : ST_QX;
                    end
                end
                ST_M0: state_reg <= ST_M1;
                ST_M1: begin
                    acc_reg   <= prod_reg[51:0];
                    state_reg <= ST_M2;
                end
                ST_M2: begin
                    det_reg   <= det_diff[36:16];
                    state_reg <= ST_M3;
                end
                ST_M3: begin
                    acc_reg   <= prod_reg[51:0];
                    state_reg <= ST_M4;
                end
                ST_M4: begin
                    tnx_reg   <= tn_diff;
                    state_reg <= ST_M5;
                end
                ST_M5: begin
                    acc_reg   <= prod_reg[51:0];
                    state_reg <= ST_M6;
                end
                ST_M6: begin
                    tny_reg   <= tn_diff;
                    state_reg <= ST_M7;
                end
                ST_M7: begin
                    if (det_reg == 21'sd0) begin
                        cam_reg    <= '0;
                        centre_reg <= '0;
                        hh_reg     <= '0;
                        ww_reg     <= '0;
                        left_reg   <= '0;
                        right_reg  <= '0;
                        top_reg    <= '0;
                        bottom_reg <= '0;
                        state_reg  <= ST_DONE;
                    end else begin
                        div_req_reg.dividend <= mag64(64'(tny_reg));
                        div_req_reg.divisor  <= mag64(64'(det_reg));
                        neg_reg   <= tny_reg[51] ^ det_reg[20];
                        state_reg <= ST_DQ;
                    end
                end
                ST_DQ: begin
                    if (div_rsp.done) begin
                        if (neg_reg || qm == '0) begin
                            cam_reg    <= '0;
                            centre_reg <= '0;
                            hh_reg     <= '0;
                            ww_reg     <= '0;
                            left_reg   <= '0;
                            right_reg  <= '0;
                            top_reg    <= '0;
                            bottom_reg <= '0;
                            state_reg  <= ST_DONE;
                        end else begin
                            cam_reg   <= cam_sat;
                            state_reg <= ST_MC0;
                        end
                    end
                end
                ST_MC0: state_reg <= ST_MC1;
                ST_MC1: begin
                    div_req_reg.dividend <= mag64($signed(prod_reg[63:0]));
                    div_req_reg.divisor  <= mag64(64'(tny_reg));
                    neg_reg   <= prod_reg[63] ^ tny_reg[51];
                    state_reg <= ST_DC;
                end
                ST_DC: begin
                    if (div_rsp.done) begin
                        centre_reg           <= centre_sat;
                        div_req_reg.dividend <= {35'd0, hs, 16'd0};
                        div_req_reg.divisor  <= {33'd0, cam_reg};
                        neg_reg   <= 1'b0;
                        state_reg <= ST_DH;
                    end
                end
                ST_DH: begin
                    if (div_rsp.done) begin
                        hh_reg               <= size_sat;
                        div_req_reg.dividend <= {35'd0, ws, 16'd0};
                        div_req_reg.divisor  <= {33'd0, cam_reg};
                        state_reg <= ST_DW;
                    end
                end
                ST_DW: begin
                    if (div_rsp.done) begin
                        ww_reg    <= size_sat;
                        state_reg <= ST_BOX;
                    end
                end
                ST_BOX: begin
                    top_reg    <= row_start;
                    bottom_reg <= row_end;
                    left_reg   <= col_start;
                    right_reg  <= col_end;
                    state_reg  <= ST_DONE;
                end
                ST_QX: begin
                    if (pix_go) begin
                        div_req_reg.dividend <= mag64(nx);
                        div_req_reg.divisor  <= {48'd0, ww_reg};
                        neg_reg   <= nx[63];
                        state_reg <= ST_DX;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DX: begin
                    if (div_rsp.done) begin
                        texx_reg             <= tex_sat;
                        div_req_reg.dividend <= mag64(ny);
                        div_req_reg.divisor  <= {48'd0, hh_reg};
                        neg_reg   <= ny[63];
                        state_reg <= ST_DY;
                    end
                end
                ST_DY: begin
                    if (div_rsp.done) begin
                        texy_reg  <= tex_sat;
                        draw_reg  <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_res_reg.visible    <= (cam_reg != 31'd0);
                        m_res_reg.box_left   <= left_reg;
                        m_res_reg.box_right  <= right_reg;
                        m_res_reg.box_top    <= top_reg;
                        m_res_reg.box_bottom <= bottom_reg;
                        m_res_reg.draw_pixel <= draw_reg;
                        m_res_reg.texel_x    <= texx_reg;
                        m_res_reg.texel_y    <= texy_reg;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sprite_projection_texcoord_core.sv =====
// A load transaction takes seven multiplies and four divisions, and stops early if
// the sprite turns out hidden; a pixel transaction takes two divisions, none if not
// drawn. The back end handles one transaction at a time and takes no new one before
// the last is through; every division goes to the shared radix-2 divider.
// Reset: synchronous active-low aresetn restores the camera registers and
// clears the kept sprite, the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module sprite_projection_texcoord_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [spt_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [spt_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_opcode,
    input  wire logic signed [31:0]              s_sprite_pos_x,
    input  wire logic signed [31:0]              s_sprite_pos_y,
    input  wire logic [11:0]                     s_column,
    input  wire logic [11:0]                     s_row,
    input  wire logic [30:0]                     s_column_depth,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_visible,
    output logic [11:0]                          m_box_left,
    output logic [11:0]                          m_box_right,
    output logic [11:0]                          m_box_top,
    output logic [11:0]                          m_box_bottom,
    output logic                                 m_draw_pixel,
    output logic [7:0]                           m_texel_x,
    output logic [7:0]                           m_texel_y
);
    import spt_pkg::*;

    cfg_t     cfg_reg;
    item_t    in_item;
    item_t    q_item;
    logic     q_valid;
    logic     q_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;
    result_t  res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.player_pos_x   <= 32'sd0;
            cfg_reg.player_pos_y   <= 32'sd0;
            cfg_reg.view_dir_x     <= 18'sd65536;
            cfg_reg.view_dir_y     <= 18'sd0;
            cfg_reg.camera_plane_x <= 18'sd0;
            cfg_reg.camera_plane_y <= 18'sd43254;
            cfg_reg.screen_width   <= 13'd640;
            cfg_reg.screen_height  <= 13'd480;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_PLAYER_POS_X:   cfg_reg.player_pos_x   <= $signed(cfg_wr_data);
                REG_PLAYER_POS_Y:   cfg_reg.player_pos_y   <= $signed(cfg_wr_data);
                REG_VIEW_DIR_X:     cfg_reg.view_dir_x     <= $signed(cfg_wr_data[17:0]);
                REG_VIEW_DIR_Y:     cfg_reg.view_dir_y     <= $signed(cfg_wr_data[17:0]);
                REG_CAMERA_PLANE_X: cfg_reg.camera_plane_x <= $signed(cfg_wr_data[17:0]);
                REG_CAMERA_PLANE_Y: cfg_reg.camera_plane_y <= $signed(cfg_wr_data[17:0]);
                REG_SCREEN_WIDTH:   cfg_reg.screen_width   <= cfg_wr_data[12:0];
                REG_SCREEN_HEIGHT:  cfg_reg.screen_height  <= cfg_wr_data[12:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign in_item.opcode       = s_opcode;
    assign in_item.sprite_pos_x = s_sprite_pos_x;
    assign in_item.sprite_pos_y = s_sprite_pos_y;
    assign in_item.column       = s_column;
    assign in_item.row          = s_row;
    assign in_item.column_depth = s_column_depth;

    spt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    spt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    spt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_visible    = res.visible;
    assign m_box_left   = res.box_left;
    assign m_box_right  = res.box_right;
    assign m_box_top    = res.box_top;
    assign m_box_bottom = res.box_bottom;
    assign m_draw_pixel = res.draw_pixel;
    assign m_texel_x    = res.texel_x;
    assign m_texel_y    = res.texel_y;

endmodule
`default_nettype wire

// ===== hdl/spt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module spt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_visible,
    input wire logic [11:0] m_box_left,
    input wire logic [11:0] m_box_right,
    input wire logic [11:0] m_box_top,
    input wire logic [11:0] m_box_bottom,
    input wire logic        m_draw_pixel,
    input wire logic [7:0]  m_texel_x,
    input wire logic [7:0]  m_texel_y
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_draw_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_draw_pixel |-> m_visible && (m_box_left < m_box_right)
            && (m_box_top < m_box_bottom))
        else $error("pixel drawn outside a visible box");

    a_texel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_draw_pixel |-> (m_texel_x == 8'd0) && (m_texel_y == 8'd0))
        else $error("texel set without draw");

    a_hidden_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |-> (m_box_left == 12'd0) && (m_box_right == 12'd0)
            && (m_box_top == 12'd0) && (m_box_bottom == 12'd0))
        else $error("invisible sprite with a box");

endmodule

bind sprite_projection_texcoord_core spt_checker u_spt_checker (.*);
`default_nettype wire
